// ===== sv/stack_bytecode_verifier_defines.svh =====
// Assertion macros used by the verifier's checker file (sbv_checker.sv).
`ifndef STACK_BYTECODE_VERIFIER_DEFINES_SVH
`define STACK_BYTECODE_VERIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbv_pkg.sv =====
// Shared constants, types and opcode decode for the bytecode verifier.
`default_nettype none
package sbv_pkg;

  localparam int MAX_CODE  = 4096;
  localparam int MAX_JUMPS = 2048;
  localparam int QDEPTH    = 4;

  localparam int MAP_AW = $clog2(MAX_CODE);
  localparam int POS_W  = $clog2(MAX_CODE + 1);
  localparam int JIDX_W = $clog2(MAX_JUMPS);
  localparam int JCNT_W = $clog2(MAX_JUMPS + 1);
  localparam int CMP_W  = (POS_W > 16) ? POS_W : 16;

  // opcodes
  localparam logic [7:0] OP_LDC   = 8'h01;
  localparam logic [7:0] OP_LDA   = 8'h02;
  localparam logic [7:0] OP_LDL   = 8'h03;
  localparam logic [7:0] OP_STL   = 8'h04;
  localparam logic [7:0] OP_STK_A = 8'h10;
  localparam logic [7:0] OP_STK_B = 8'h11;
  localparam logic [7:0] OP_STK_C = 8'h12;
  localparam logic [7:0] OP_STK_D = 8'h13;
  localparam logic [7:0] OP_ALU_A = 8'h20;
  localparam logic [7:0] OP_ALU_B = 8'h21;
  localparam logic [7:0] OP_JMP   = 8'h30;
  localparam logic [7:0] OP_JZ    = 8'h31;
  localparam logic [7:0] OP_JNZ   = 8'h32;
  localparam logic [7:0] OP_LIST  = 8'h40;
  localparam logic [7:0] OP_DICT  = 8'h41;
  localparam logic [7:0] OP_RET   = 8'hff;

  localparam logic [1:0] LEN_BAD = 2'd3;

  // verdict codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_LOCALS  = 4'd1;
  localparam logic [3:0] ST_OPCODE  = 4'd2;
  localparam logic [3:0] ST_TRUNC   = 4'd3;
  localparam logic [3:0] ST_CONST   = 4'd4;
  localparam logic [3:0] ST_ARG     = 4'd5;
  localparam logic [3:0] ST_LOCAL   = 4'd6;
  localparam logic [3:0] ST_JRANGE  = 4'd7;
  localparam logic [3:0] ST_JALIGN  = 4'd8;
  localparam logic [3:0] ST_CAP     = 4'd9;

  typedef struct packed {
    logic [15:0] constant_count;
    logic [7:0]  argument_count;
    logic [7:0]  local_regs;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] offset;
    logic [15:0] value;
  } err_t;

  typedef struct packed {
    logic [11:0] at;
    logic [15:0] target;
  } jent_t;

  // one event per accepted code byte, front to back
  typedef struct packed {
    logic              map_we;
    logic              map_bit;
    logic [MAP_AW-1:0] map_addr;
    logic              jump_we;
    logic [JIDX_W-1:0] jump_idx;
    jent_t             jump;
    logic              last;
    err_t              err;
    logic [POS_W-1:0]  byte_pos;
    logic [JCNT_W-1:0] jump_cnt;
    logic              locals_low;
  } ev_t;

  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] n;
    unique case (op) inside
      OP_LDC, OP_JMP, OP_JZ, OP_JNZ, OP_LIST, OP_DICT:                 n = 2'd2;
      OP_LDA, OP_LDL, OP_STL:                                          n = 2'd1;
      OP_STK_A, OP_STK_B, OP_STK_C, OP_STK_D, OP_ALU_A, OP_ALU_B, OP_RET: n = 2'd0;
      default:                                                         n = LEN_BAD;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sbv_front.sv =====
// Front end: takes code bytes, decodes instructions, checks operands, issues events.
`default_nettype none
module sbv_front
  import sbv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] in_code_byte,
  input  wire logic       in_last,
  output logic            busy,
  input  wire cfg_t       cfg,
  input  wire logic       q_full,
  input  wire logic       done,
  output logic            push,
  output ev_t             ev
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [1:0]        left_r, left_nxt;
  logic [7:0]        op_r, op_nxt;
  logic [11:0]       inst_r, inst_nxt;
  logic [7:0]        hi_r, hi_nxt;
  err_t              err_r, err_nxt;
  logic [JCNT_W-1:0] jcnt_r, jcnt_nxt;
  logic              wait_r, wait_nxt;
  logic              accept;
  logic [1:0]        len;
  logic [15:0]       value;

  assign busy   = wait_r | q_full;
  assign accept = start & ~busy;
  assign push   = accept;

  always_comb begin
    ev       = '0;
    pos_nxt  = pos_r;
    left_nxt = left_r;
    op_nxt   = op_r;
    inst_nxt = inst_r;
    hi_nxt   = hi_r;
    err_nxt  = err_r;
    jcnt_nxt = jcnt_r;
    wait_nxt = wait_r;
    len      = op_len(in_code_byte);
    value    = (op_len(op_r) == 2'd2) ? {hi_r, in_code_byte} : {8'h00, in_code_byte};
    if (done) begin
      wait_nxt = 1'b0;
    end
    if (accept) begin
      // after the first error, bytes are only counted until the last one
      if (err_r.status == ST_OK) begin
        if (pos_r >= POS_W'(MAX_CODE)) begin
          err_nxt = '{ST_CAP, 12'(pos_r), 16'h0000};
        end else begin
          ev.map_we   = 1'b1;
          ev.map_addr = MAP_AW'(pos_r);
          if (left_r == 2'd0) begin
            ev.map_bit = 1'b1;
            op_nxt     = in_code_byte;
            inst_nxt   = 12'(pos_r);
            if (len == LEN_BAD) begin
              err_nxt = '{ST_OPCODE, 12'(pos_r), {8'h00, in_code_byte}};
            end else begin
              left_nxt = len;
            end
          end else if (left_r == 2'd2) begin
            hi_nxt   = in_code_byte;
            left_nxt = 2'd1;
          end else begin
            left_nxt = 2'd0;
            unique case (op_r) inside
              OP_LDC: begin
                if (value >= cfg.constant_count) err_nxt = '{ST_CONST, inst_r, value};
              end
              OP_LDA: begin
                if (value >= 16'(cfg.argument_count)) err_nxt = '{ST_ARG, inst_r, value};
              end
              OP_LDL, OP_STL: begin
                if (value >= 16'(cfg.local_regs)) err_nxt = '{ST_LOCAL, inst_r, value};
              end
              OP_JMP, OP_JZ, OP_JNZ: begin
                if (jcnt_r < JCNT_W'(MAX_JUMPS)) begin
                  ev.jump_we  = 1'b1;
                  ev.jump_idx = JIDX_W'(jcnt_r);
                  ev.jump     = '{inst_r, value};
                  jcnt_nxt    = jcnt_r + JCNT_W'(1);
                end else begin
                  err_nxt = '{ST_CAP, inst_r, 16'h0000};
                end
              end
              default: ;
            endcase
          end
        end
      end
      if (pos_r < POS_W'(MAX_CODE)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (in_last) begin
        if (err_nxt.status == ST_OK && left_nxt != 2'd0) begin
          err_nxt = '{ST_TRUNC, inst_nxt, {8'h00, op_nxt}};
        end
        ev.last       = 1'b1;
        ev.err        = err_nxt;
        ev.byte_pos   = pos_nxt;
        ev.jump_cnt   = jcnt_nxt;
        ev.locals_low = cfg.local_regs < cfg.argument_count;
        wait_nxt      = 1'b1;
        pos_nxt       = '0;
        left_nxt      = '0;
        op_nxt        = '0;
        inst_nxt      = '0;
        hi_nxt        = '0;
        err_nxt       = '0;
        jcnt_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      left_r <= '0;
      op_r   <= '0;
      inst_r <= '0;
      hi_r   <= '0;
      err_r  <= '0;
      jcnt_r <= '0;
      wait_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      left_r <= left_nxt;
      op_r   <= op_nxt;
      inst_r <= inst_nxt;
      hi_r   <= hi_nxt;
      err_r  <= err_nxt;
      jcnt_r <= jcnt_nxt;
      wait_r <= wait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sbv_queue.sv =====
// Short event queue between the decode front end and the checking back end.
`default_nettype none
module sbv_queue
  import sbv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire ev_t  push_ev,
  input  wire logic pop,
  output ev_t       head,
  output logic      empty,
  output logic      full
);

  localparam int QAW = $clog2(QDEPTH);

  ev_t            slot_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;
  logic           do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign head   = slot_r[rd_r];
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QAW'(1);
      if (do_pop) rd_r <= rd_r + QAW'(1);
      if (push && !do_pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sbv_back.sv =====
// Back end: start map and jump list, final jump walk and verdict register.
`default_nettype none
module sbv_back
  import sbv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ev_t  head,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  output err_t      out_res
);

  typedef enum logic [1:0] {B_IDLE, B_RD, B_JMP, B_MAP} state_t;

  logic  smap [MAX_CODE];
  jent_t jmem [MAX_JUMPS];

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  bpos_r, bpos_nxt;
  logic [JCNT_W-1:0] jcnt_r, jcnt_nxt;
  logic [JCNT_W-1:0] widx_r, widx_nxt;
  logic              valid_r, valid_nxt;
  err_t              res_r, res_nxt;
  jent_t             jrd_r;
  logic              srd_r;

  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (pop && head.map_we) begin
      smap[head.map_addr] <= head.map_bit;
    end
    srd_r <= smap[MAP_AW'(jrd_r.target)];
  end

  always_ff @(posedge clk) begin
    if (pop && head.jump_we) begin
      jmem[head.jump_idx] <= head.jump;
    end
    jrd_r <= jmem[widx_r[JIDX_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    bpos_nxt  = bpos_r;
    jcnt_nxt  = jcnt_r;
    widx_nxt  = widx_r;
    valid_nxt = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop && head.last) begin
          bpos_nxt = head.byte_pos;
          jcnt_nxt = head.jump_cnt;
          widx_nxt = '0;
          if (head.locals_low) begin
            valid_nxt = 1'b1;
            res_nxt   = '{ST_LOCALS, 12'h000, 16'h0000};
          end else if (head.err.status != ST_OK || head.jump_cnt == '0) begin
            valid_nxt = 1'b1;
            res_nxt   = head.err;
          end else begin
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        state_nxt = B_JMP;
      end
      B_JMP: begin
        if (CMP_W'(jrd_r.target) >= CMP_W'(bpos_r)) begin
          valid_nxt = 1'b1;
          res_nxt   = '{ST_JRANGE, jrd_r.at, jrd_r.target};
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_MAP;
        end
      end
      B_MAP: begin
        if (!srd_r) begin
          valid_nxt = 1'b1;
          res_nxt   = '{ST_JALIGN, jrd_r.at, jrd_r.target};
          state_nxt = B_IDLE;
        end else if (widx_r + JCNT_W'(1) == jcnt_r) begin
          valid_nxt = 1'b1;
          res_nxt   = '0;
          state_nxt = B_IDLE;
        end else begin
          widx_nxt  = widx_r + JCNT_W'(1);
          state_nxt = B_RD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      widx_r  <= '0;
      jcnt_r  <= '0;
      bpos_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      widx_r  <= widx_nxt;
      jcnt_r  <= jcnt_nxt;
      bpos_r  <= bpos_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/stack_bytecode_verifier.sv =====
// Top level of the bytecode verifier: config registers and the front/queue/back chain.
`default_nettype none
// Usage
//   Code bytes of one function enter on in_code_byte, one transfer per cycle
//   while start is high and busy is low; in_last marks the final byte.
//   One verdict per function comes back on out_status, out_error_offset and
//   out_bad_value, shown for exactly one cycle with out_valid high.
//   The receiver cannot stall; the verdict must be taken in that cycle.
//   Throughput: one byte per cycle within a function.
//   After the last byte, the verdict comes straight from the back end when a
//   decode error is found or no jump was stored; else the jump walk goes
//   through each stored jump in turn: jump list read, then range check with
//   start map read, then the start map check. The walk stops at the first bad jump.
//   busy stays high from the last byte until the verdict cycle, so the next
//   function's first byte is taken in the cycle after the verdict.
//   The count registers sit on the APB port (0x0 constants, 0x4 arguments, 0x8
//   locals); the user writes them only while no function is in flight, which the block
//   does not enforce. Reset clears the registers, the decode state and the queue;
//   the start map needs no clearing since every byte of a function rewrites its own entry.
module stack_bytecode_verifier
  import sbv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_code_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic [11:0]      out_error_offset,
  output logic [15:0]      out_bad_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_CONST = 2'd0;
  localparam logic [1:0] REG_ARG   = 2'd1;
  localparam logic [1:0] REG_LOCAL = 2'd2;

  cfg_t cfg_r;
  logic cfg_we;
  logic q_full, q_empty, push, pop, done;
  ev_t  push_ev, head;
  err_t res;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_CONST: cfg_r.constant_count <= pwdata[15:0];
        REG_ARG:   cfg_r.argument_count <= pwdata[7:0];
        REG_LOCAL: cfg_r.local_regs     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CONST: prdata = {16'h0000, cfg_r.constant_count};
      REG_ARG:   prdata = {24'h000000, cfg_r.argument_count};
      REG_LOCAL: prdata = {24'h000000, cfg_r.local_regs};
      default:   prdata = 32'h0000_0000;
    endcase
  end

  sbv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_code_byte (in_code_byte),
    .in_last      (in_last),
    .busy         (busy),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .done         (done),
    .push         (push),
    .ev           (push_ev)
  );

  sbv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  sbv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (done),
    .out_res   (res)
  );

  assign out_valid        = done;
  assign out_status       = res.status;
  assign out_error_offset = res.offset;
  assign out_bad_value    = res.value;

endmodule
`default_nettype wire

// ===== sv/sbv_checker.sv =====
// Port-level checks on the verifier, bound to the top level.
`default_nettype none
`include "stack_bytecode_verifier_defines.svh"
module sbv_checker
  import sbv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic [3:0]  out_status,
  input wire logic [11:0] out_error_offset,
  input wire logic [15:0] out_bad_value
);

  `SBV_ASSERT_NEXT(a_strobe_one_cycle, clk, rst_n, out_valid, !out_valid, "verdict strobe held")
  `SBV_ASSERT_NEXT(a_last_blocks, clk, rst_n, start && !busy && in_last, busy, "not busy after last")
  `SBV_ASSERT_NOW(a_verdict_while_busy, clk, rst_n, out_valid, busy, "verdict with no function open")
  `SBV_ASSERT_NOW(a_ok_is_clean, clk, rst_n, out_valid && (out_status == ST_OK || out_status == ST_LOCALS), out_error_offset == 12'h000 && out_bad_value == 16'h0000, "detail set on clean verdict")

endmodule

bind stack_bytecode_verifier sbv_checker u_sbv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_error_offset (out_error_offset),
  .out_bad_value    (out_bad_value)
);
`default_nettype wire

// ===== test/tb_stack_bytecode_verifier.sv =====
// Self-checking testbench for the bytecode verifier: directed table and random functions.
`timescale 1ns / 100ps

module tb_stack_bytecode_verifier;
  import sbv_pkg::*;

  localparam int unsigned CFG_CONSTANTS = 0;
  localparam int unsigned CFG_ARGUMENTS = 1;
  localparam int unsigned CFG_LOCALS    = 2;

  localparam int unsigned ILLEGAL_LEN = 3;
  localparam logic [7:0] ILLEGAL_ZERO = 8'h00;
  localparam logic [7:0] ILLEGAL_GAP  = 8'h22;

  localparam int IDLE_PCT [3] = '{26, 63, 0};

  localparam logic [7:0] VALID_OPS [16] = '{
    OP_LDC, OP_LDA, OP_LDL, OP_STL, OP_STK_A, OP_STK_B, OP_STK_C, OP_STK_D,
    OP_ALU_A, OP_ALU_B, OP_JMP, OP_JZ, OP_JNZ, OP_LIST, OP_DICT, OP_RET
  };

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    logic       typed;
    err_t       want;
  } dir_row_t;

  localparam err_t NO_VERDICT = '0;

  // counts are all zero here, straight after reset
  localparam dir_row_t DIRECTED [25] = '{
    '{OP_RET,       1'b1, 1'b1, '{ST_OK, 12'd0, 16'h0000}},
    '{ILLEGAL_ZERO, 1'b0, 1'b0, NO_VERDICT},
    '{OP_LDC,       1'b1, 1'b1, '{ST_OPCODE, 12'd0, 16'h0000}},
    '{OP_STK_A,     1'b0, 1'b0, NO_VERDICT},
    '{ILLEGAL_GAP,  1'b1, 1'b1, '{ST_OPCODE, 12'd1, {8'h00, ILLEGAL_GAP}}},
    '{OP_LDC,       1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b1, 1'b1, '{ST_TRUNC, 12'd0, {8'h00, OP_LDC}}},
    '{OP_LDC,       1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b1, 1'b1, '{ST_CONST, 12'd0, 16'h0000}},
    '{OP_LDA,       1'b0, 1'b0, NO_VERDICT},
    '{8'hff,        1'b1, 1'b1, '{ST_ARG, 12'd0, 16'h00ff}},
    '{OP_STL,       1'b0, 1'b0, NO_VERDICT},
    '{8'h80,        1'b1, 1'b1, '{ST_LOCAL, 12'd0, 16'h0080}},
    '{OP_JMP,       1'b0, 1'b0, NO_VERDICT},
    '{8'hff,        1'b0, 1'b0, NO_VERDICT},
    '{8'hff,        1'b1, 1'b1, '{ST_JRANGE, 12'd0, 16'hffff}},
    '{OP_STK_B,     1'b0, 1'b0, NO_VERDICT},
    '{OP_JZ,        1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b0, 1'b0, NO_VERDICT},
    '{8'h02,        1'b0, 1'b0, NO_VERDICT},
    '{OP_STK_C,     1'b1, 1'b1, '{ST_JALIGN, 12'd1, 16'h0002}},
    '{OP_JNZ,       1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b0, 1'b0, NO_VERDICT},
    '{8'h00,        1'b1, 1'b1, '{ST_OK, 12'd0, 16'h0000}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_code_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic [3:0]  out_status;
  logic [11:0] out_error_offset;
  logic [15:0] out_bad_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stack_bytecode_verifier uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_code_byte(in_code_byte), .in_last(in_last),
    .out_valid(out_valid), .out_status(out_status),
    .out_error_offset(out_error_offset), .out_bad_value(out_bad_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // counts as the block holds them
  logic [15:0] cnt_const = '0;
  logic [7:0]  cnt_arg = '0;
  logic [7:0]  cnt_local = '0;

  // per-function decode state
  bit          seen_start [MAX_CODE];
  jent_t       pending_jumps [$];
  int unsigned bytes_seen = 0;
  int unsigned operand_left = 0;
  logic [7:0]  cur_op = '0;
  int unsigned cur_at = 0;
  logic [7:0]  operand_hi = '0;
  err_t        first_fault = '0;

  err_t        verdicts_due [$];
  logic [7:0]  prog [$];
  int          idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned byte_count = 0;
  int unsigned prog_count = 0;
  int unsigned verdicts_seen = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  function automatic int unsigned operand_bytes(input logic [7:0] op);
    case (op)
      OP_LDC, OP_JMP, OP_JZ, OP_JNZ, OP_LIST, OP_DICT: return 2;
      OP_LDA, OP_LDL, OP_STL: return 1;
      OP_STK_A, OP_STK_B, OP_STK_C, OP_STK_D, OP_ALU_A, OP_ALU_B, OP_RET: return 0;
      default: return ILLEGAL_LEN;
    endcase
  endfunction

  // only the first fault of a function sticks
  function automatic void note_fault(input logic [3:0] code, input int unsigned at,
                                     input int unsigned value);
    if (first_fault.status == ST_OK) begin
      first_fault.status = code;
      first_fault.offset = at[11:0];
      first_fault.value  = value[15:0];
    end
  endfunction

  function automatic void close_operand(input int unsigned value);
    jent_t ent;
    if (cur_op == OP_LDC) begin
      if (value >= cnt_const) note_fault(ST_CONST, cur_at, value);
    end else if (cur_op == OP_LDA) begin
      if (value >= cnt_arg) note_fault(ST_ARG, cur_at, value);
    end else if (cur_op == OP_LDL || cur_op == OP_STL) begin
      if (value >= cnt_local) note_fault(ST_LOCAL, cur_at, value);
    end else if (cur_op == OP_JMP || cur_op == OP_JZ || cur_op == OP_JNZ) begin
      if (pending_jumps.size() < MAX_JUMPS) begin
        ent.at = cur_at[11:0];
        ent.target = value[15:0];
        pending_jumps = {pending_jumps, ent};
      end else begin
        note_fault(ST_CAP, cur_at, 0);
      end
    end
  endfunction

  // advances the decode state by one code byte; returns 1 with the verdict on the last byte
  function automatic bit track_code_byte(input logic [7:0] b, input logic fin,
                                         output err_t verdict);
    int unsigned n;
    verdict = '0;
    if (first_fault.status == ST_OK) begin
      if (bytes_seen >= MAX_CODE) begin
        note_fault(ST_CAP, bytes_seen, 0);
      end else if (operand_left == 0) begin
        n = operand_bytes(b);
        seen_start[bytes_seen] = 1'b1;
        cur_op = b;
        cur_at = bytes_seen;
        if (n == ILLEGAL_LEN) note_fault(ST_OPCODE, bytes_seen, b);
        else operand_left = n;
      end else if (operand_left == 2) begin
        operand_hi = b;
        operand_left = 1;
      end else begin
        operand_left = 0;
        if (operand_bytes(cur_op) == 2) close_operand({operand_hi, b});
        else close_operand(b);
      end
    end
    if (bytes_seen < MAX_CODE) bytes_seen++;
    if (!fin) return 1'b0;

    if (first_fault.status == ST_OK && operand_left != 0)
      note_fault(ST_TRUNC, cur_at, cur_op);
    if (first_fault.status == ST_OK) begin
      foreach (pending_jumps[i]) begin
        if (pending_jumps[i].target >= bytes_seen) begin
          note_fault(ST_JRANGE, pending_jumps[i].at, pending_jumps[i].target);
          break;
        end
        if (pending_jumps[i].target >= MAX_CODE || !seen_start[pending_jumps[i].target]) begin
          note_fault(ST_JALIGN, pending_jumps[i].at, pending_jumps[i].target);
          break;
        end
      end
    end
    verdict = first_fault;
    if (cnt_local < cnt_arg) verdict = '{ST_LOCALS, 12'd0, 16'd0};

    seen_start = '{default: 1'b0};
    pending_jumps.delete();
    bytes_seen = 0;
    operand_left = 0;
    cur_op = '0;
    cur_at = 0;
    operand_hi = '0;
    first_fault = '0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input err_t want);
    err_t got;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    in_code_byte <= b;
    in_last <= fin;
    do @(posedge clk); while (busy);
    byte_count++;
    if (track_code_byte(b, fin, got)) begin
      if (typed) got = want;
      verdicts_due = {verdicts_due, got};
      prog_count++;
    end
  endtask

  task automatic send_program();
    foreach (prog[i]) send_byte(prog[i], i == prog.size() - 1, 1'b0, NO_VERDICT);
  endtask

  // sender holds off until every verdict has come back, then a little longer
  task automatic settle();
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input int unsigned idx,
                              input logic [31:0] data, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 4'(4 * idx);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    logic [31:0] back;
    logic [31:0] held;
    apb_transfer(1'b1, idx, value, back);
    case (idx)
      CFG_CONSTANTS: cnt_const = value[15:0];
      CFG_ARGUMENTS: cnt_arg   = value[7:0];
      default:       cnt_local = value[7:0];
    endcase
    case (idx)
      CFG_CONSTANTS: held = {16'd0, cnt_const};
      CFG_ARGUMENTS: held = {24'd0, cnt_arg};
      default:       held = {24'd0, cnt_local};
    endcase
    apb_transfer(1'b0, idx, '0, back);
    if (back !== held) report_mismatch("register read-back", back, held);
  endtask

  task automatic apply_setting(input int unsigned k);
    int unsigned c, a, l;
    settle();
    case (k % 4)
      0: begin
        c = $urandom_range(1, 40);
        a = $urandom_range(0, 6);
        l = a + $urandom_range(0, 6);
      end
      1: begin
        c = 65535;
        a = 255;
        l = 255;
      end
      2: begin
        // fewer locals than arguments: every verdict is overridden
        c = $urandom_range(0, 65535);
        a = $urandom_range(1, 255);
        l = $urandom_range(0, a - 1);
      end
      default: begin
        c = 0;
        a = 0;
        l = 0;
      end
    endcase
    write_reg(CFG_CONSTANTS, c);
    write_reg(CFG_ARGUMENTS, a);
    write_reg(CFG_LOCALS, l);
  endtask

  function automatic int unsigned pick_index(input int unsigned limit, input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0 || limit == 0) return $urandom_range(0, span - 1);
    if (roll == 1 && limit < span) return limit;
    return $urandom_range(0, limit - 1);
  endfunction

  // mostly well-formed functions with random content, some corrupted or pure noise
  task automatic compose_program();
    int unsigned n_instr, kind, idx;
    int unsigned starts_q [$];
    int unsigned jump_slots [$];
    logic [7:0] op;
    logic [15:0] target;
    prog.delete();
    n_instr = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 10);
    for (int i = 0; i < n_instr; i++) begin
      op = VALID_OPS[$urandom_range(0, 15)];
      starts_q = {starts_q, prog.size()};
      prog = {prog, op};
      case (op)
        OP_LDC: begin
          target = 16'(pick_index(cnt_const, 65536));
          prog = {prog, target[15:8], target[7:0]};
        end
        OP_LDA: prog = {prog, 8'(pick_index(cnt_arg, 256))};
        OP_LDL, OP_STL: prog = {prog, 8'(pick_index(cnt_local, 256))};
        OP_JMP, OP_JZ, OP_JNZ: begin
          jump_slots = {jump_slots, prog.size()};
          prog = {prog, 8'h00, 8'h00};
        end
        OP_LIST, OP_DICT: begin
          prog = {prog, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        end
        default: ;
      endcase
    end
    foreach (jump_slots[j]) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) target = 16'(starts_q[$urandom_range(0, starts_q.size() - 1)]);
      else if (kind < 8) target = 16'($urandom_range(0, prog.size() - 1));
      else if (kind == 8) target = 16'(prog.size());
      else target = 16'($urandom_range(0, 65535));
      prog[jump_slots[j]] = target[15:8];
      prog[jump_slots[j] + 1] = target[7:0];
    end
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      idx = $urandom_range(0, prog.size() - 1);
      prog[idx] = 8'($urandom_range(0, 255));
    end else if (kind == 1 && prog.size() > 1) begin
      prog = prog[0:$-1];
    end else if (kind == 2) begin
      prog.delete();
      repeat ($urandom_range(1, 8)) prog = {prog, 8'($urandom_range(0, 255))};
    end
  endtask

  always @(posedge clk) begin
    err_t due;
    if (rst_n && out_valid) begin
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with none due", {out_status, out_error_offset, out_bad_value}, 0);
      end else begin
        due = verdicts_due.pop_front();
        if (out_status !== due.status)
          report_mismatch("status", out_status, due.status);
        if (out_error_offset !== due.offset)
          report_mismatch("error_offset", out_error_offset, due.offset);
        if (out_bad_value !== due.value)
          report_mismatch("bad_value", out_bad_value, due.value);
      end
    end
  end

  initial begin
    int unsigned mark;
    bit paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].code, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = IDLE_PCT[mode];
      for (int seg = 0; seg < 3; seg++) begin
        apply_setting(mode * 3 + seg);
        mark = byte_count;
        while (byte_count - mark < 80) begin
          compose_program();
          send_program();
          if (mode == 0 && seg == 1 && !paused && byte_count - mark > 40) begin
            settle();
            paused = 1'b1;
          end
        end
      end
    end

    settle();
    $display("Checked %0d verdicts from %0d functions (%0d code bytes)",
             verdicts_seen, prog_count, byte_count);
    $display("Counts swept through zero, full-scale, mixed and locals-below-arguments settings");
    if (mismatches == 0) begin
      $display("stack_bytecode_verifier: match");
    end else begin
      $display("stack_bytecode_verifier: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("stack_bytecode_verifier: mismatch");
    $finish;
  end

endmodule
